// ----- hw/rtl/tts_pkg.sv -----
// ----------------------------------------------------------------------------
// tts_pkg: shared constants and helpers for the tridiagonal solver
// Q16.16 widths, status codes and saturation helpers.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned MaxRows = 64;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusZeroPiv  = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  localparam logic signed [31:0] SatMax = 32'sh7fffffff;
  localparam logic signed [31:0] SatMin = 32'sh80000000;

  // saturate a 66-bit signed value to 32 bits
  function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7fff_ffff) r = SatMax;
    else if (v < -66'sh0_8000_0000) r = SatMin;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- hw/rtl/tridiagonal_thomas_solver.sv -----
// ----------------------------------------------------------------------------
// tridiagonal_thomas_solver: Thomas algorithm solver, Q16.16
// Forward sweep per row, back substitution on the last row.
// ----------------------------------------------------------------------------
// Each accepted row word holds in_stall high while it is worked on: one
// state for the pivot, one for the right-hand side multiply and subtract, two
// 49-step passes of the shared divider (a start state and a wait for its done
// flag each), a store and a hold state to let the read port settle.
// A zero pivot skips both divisions and goes straight to the store; a row
// past capacity is dropped at once. The last row then emits one result word
// per stored row, highest row first, each through S_RD and S_RDW for the
// memory read, S_BMUL for the multiply and subtract and S_BOUT to present
// the word, plus any out_stall. in_stall is high while a row or the back
// substitution is in progress. All arithmetic saturates.
module tridiagonal_thomas_solver #(
  parameter int unsigned MAX_ROWS = tts_pkg::MaxRows
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_lower_coef,
  input  logic signed [31:0] in_diag_coef,
  input  logic signed [31:0] in_upper_coef,
  input  logic signed [31:0] in_rhs_value,
  input  logic               in_last_row,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_solution,
  output logic [5:0]         out_row_index,
  output logic [1:0]         out_status,
  output logic               out_last_result
);

  localparam logic [3:0] S_IDLE = 4'd0, S_MUL1 = 4'd1, S_PIV = 4'd2, S_DIVC = 4'd3,
                         S_WAITC = 4'd4, S_DIVD = 4'd5, S_WAITD = 4'd6,
                         S_STORE = 4'd7, S_RD = 4'd8, S_RDW = 4'd9, S_BMUL = 4'd10,
                         S_BOUT = 4'd11, S_HOLD = 4'd12;

  logic [3:0]  st_r;
  logic [6:0]  cnt_r;
  logic [1:0]  err_r;
  logic        last_r;
  logic signed [31:0] lo_r, dg_r, up_r, rh_r, cprev_r, dprev_r, piv_r, c_r, num_r;
  logic signed [31:0] x_r;
  logic [5:0]  bi_r;
  logic        first_r;
  logic signed [31:0] mem_u [MAX_ROWS];
  logic signed [31:0] mem_d [MAX_ROWS];
  logic signed [31:0] rd_u_r, rd_d_r;
  logic        wr_en;
  logic [5:0]  wr_a, rd_a;
  logic signed [31:0] wr_u, wr_d;

  // shared multiplier with Q16.16 rounding
  logic signed [31:0] ma, mb, mres;
  logic signed [63:0] prod;
  always_comb begin
    prod = ma * mb;
    mres = tts_pkg::sat66(66'(($signed({prod[63], prod[63], prod}) + 66'sd32768) >>> 16));
  end

  logic               dv_start;
  logic signed [31:0] dv_num, dv_quo;
  logic               dv_done;
  tts_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(piv_r),
    .done(dv_done), .quo(dv_quo)
  );

  logic signed [31:0] sub_a, sub_b, sub_res;
  assign sub_res = tts_pkg::sat66(66'(sub_a) - 66'(sub_b));

  always_comb begin
    ma = lo_r; mb = cprev_r; sub_a = dg_r; sub_b = mres;
    dv_start = 1'b0; dv_num = up_r;
    case (st_r)
      S_MUL1:  begin ma = lo_r; mb = dprev_r; sub_a = rh_r; end
      S_DIVC:  begin dv_start = 1'b1; dv_num = up_r; end
      S_DIVD:  begin dv_start = 1'b1; dv_num = num_r; end
      S_BMUL:  begin ma = rd_u_r; mb = x_r; sub_a = rd_d_r; end
      default: ;
    endcase
  end

  assign wr_en = (st_r == S_STORE) && (cnt_r < 7'(MAX_ROWS));
  assign wr_a  = cnt_r[5:0];
  assign wr_u  = (piv_r == 0) ? '0 : c_r;
  assign wr_d  = (piv_r == 0) ? '0 : dv_quo;
  // point the read port at the previous row while waiting for the next one
  assign rd_a  = (st_r inside {S_IDLE, S_HOLD}) ? 6'(cnt_r - 7'd1) : bi_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_u[wr_a] <= wr_u;
      mem_d[wr_a] <= wr_d;
    end
    rd_u_r <= mem_u[rd_a];
    rd_d_r <= mem_d[rd_a];
  end

  assign in_stall = (st_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; err_r <= tts_pkg::StatusOk;
      out_valid <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (in_valid) begin
          lo_r <= (cnt_r == 0) ? '0 : in_lower_coef;
          dg_r <= in_diag_coef; rh_r <= in_rhs_value;
          up_r <= in_last_row ? '0 : in_upper_coef;
          last_r <= in_last_row;
          // row zero has no predecessor: take zeros, not the store
          cprev_r <= (cnt_r == 0) ? '0 : rd_u_r;
          dprev_r <= (cnt_r == 0) ? '0 : rd_d_r;
          if (cnt_r >= 7'(MAX_ROWS)) begin
            err_r <= tts_pkg::StatusOverflow;
            st_r  <= in_last_row ? S_RD : S_IDLE;
            bi_r  <= 6'(cnt_r - 7'd1); first_r <= 1'b1;
          end else st_r <= S_PIV;
        end
        S_PIV: begin
          piv_r <= sub_res; st_r <= S_MUL1;
        end
        S_MUL1: begin
          num_r <= sub_res;
          if (piv_r == 0) begin
            if (err_r != tts_pkg::StatusOverflow) err_r <= tts_pkg::StatusZeroPiv;
            st_r <= S_STORE;
          end else st_r <= S_DIVC;
        end
        S_DIVC: st_r <= S_WAITC;
        S_WAITC: if (dv_done) begin
          c_r <= dv_quo; st_r <= S_DIVD;
        end
        S_DIVD: st_r <= S_WAITD;
        S_WAITD: if (dv_done) st_r <= S_STORE;
        S_STORE: begin
          cnt_r <= cnt_r + 7'd1;
          bi_r  <= cnt_r[5:0]; first_r <= 1'b1;
          st_r  <= last_r ? S_RD : S_HOLD;
        end
        S_RD:  st_r <= S_RDW;
        S_RDW: st_r <= S_BMUL;
        S_BMUL: begin
          x_r <= first_r ? rd_d_r : sub_res;
          out_solution <= first_r ? rd_d_r : sub_res;
          out_row_index <= bi_r; out_status <= err_r;
          out_last_result <= (bi_r == 0); out_valid <= 1'b1;
          st_r <= S_BOUT;
        end
        S_BOUT: if (!out_stall) begin
          out_valid <= 1'b0; first_r <= 1'b0;
          if (bi_r == 0) begin
            cnt_r <= '0; err_r <= tts_pkg::StatusOk; st_r <= S_HOLD;
          end else begin
            bi_r <= bi_r - 6'd1; st_r <= S_RD;
          end
        end
        S_HOLD: st_r <= S_IDLE;  // let the read port settle before next row
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/tts_div.sv -----
// ----------------------------------------------------------------------------
// tts_div: iterative Q16.16 divider
// Restoring divide, one quotient bit per cycle, round to nearest away from zero,
// saturated result.
// ----------------------------------------------------------------------------
module tts_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        neg_r, neg_nxt;
  logic [47:0] rem_r, rem_nxt;   // partial remainder; un + ub/2 shifts in bitwise from q_r
  logic [48:0] q_r, q_nxt;
  logic [31:0] ub_r, ub_nxt;
  logic [48:0] part;
  logic [47:0] un;
  logic [31:0] ub;
  logic [65:0] mag;
  logic        fin_r;

  always_comb begin
    un = num[31] ? 48'(-{{16{num[31]}}, num, 16'd0}) : {num, 16'd0};
    ub = den[31] ? 32'(-den) : den;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    ub_nxt   = ub_r;
    part     = '0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd49;
      neg_nxt  = num[31] ^ den[31];
      // dividend bits held in q_r, partial remainder in rem_r
      q_nxt    = {1'b0, un} + 49'(ub >> 1);
      rem_nxt  = '0;
      ub_nxt   = ub;
    end else if (busy_r) begin
      part = {rem_r, q_r[48]};
      if (part >= {17'd0, ub_r}) begin
        rem_nxt = 48'(part - {17'd0, ub_r});
        q_nxt   = {q_r[47:0], 1'b1};
      end else begin
        rem_nxt = part[47:0];
        q_nxt   = {q_r[47:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
    mag  = {17'd0, q_r};
    quo  = tts_pkg::sat66(neg_r ? -$signed(mag) : $signed(mag));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    ub_r  <= ub_nxt;
  end

  // flag completion, registered together with the last quotient bit
  always_ff @(posedge clk) begin
    if (!rst_n) fin_r <= 1'b0;
    else fin_r <= busy_r && (cnt_r == 6'd1);
  end

  assign done = fin_r;

endmodule

// ----- hw/rtl/tts_checker.sv -----
// ----------------------------------------------------------------------------
// tts_checker: port-level checks for the tridiagonal solver
// Watches handshake and result ordering on the top level ports.
// ----------------------------------------------------------------------------
module tts_props (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] out_row_index,
  input logic       out_last_result
);

  // a stalled result word stays valid with the same row index
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row_index))
    else $error("stalled result changed");

  // last flag only on row zero
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_result == (out_row_index == 6'd0)))
    else $error("last flag mismatch");

  // no new row taken while results are pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during output");

endmodule

bind tridiagonal_thomas_solver tts_props u_tts_props (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_row_index(out_row_index),
  .out_last_result(out_last_result)
);

// ----- bench/tts_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_checker: result checker for the tridiagonal solver
// Watches both channels, runs its own Thomas sweep on every accepted row word
// and compares each accepted result word with the oldest predicted solution.
// ----------------------------------------------------------------------------
module tts_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_lower_coef,
  input  logic signed [31:0] in_diag_coef,
  input  logic signed [31:0] in_upper_coef,
  input  logic signed [31:0] in_rhs_value,
  input  logic               in_last_row,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_solution,
  input  logic [5:0]         out_row_index,
  input  logic [1:0]         out_status,
  input  logic               out_last_result,
  output int                 fail_count,
  output int                 pending_count,
  output int                 solves_seen
);

  typedef struct packed {
    logic signed [31:0] solution;
    logic [5:0]         row_index;
    logic [1:0]         status;
    logic               last_result;
  } soln_t;

  soln_t              soln_q[$];
  logic signed [31:0] c_mem [tts_pkg::MaxRows];
  logic signed [31:0] d_mem [tts_pkg::MaxRows];
  int                 rows_held;
  logic [1:0]         run_status;

  function automatic logic signed [31:0] clamp(input longint v);
    if (v > 64'sd2147483647) return tts_pkg::SatMax;
    if (v < -64'sd2147483648) return tts_pkg::SatMin;
    return v[31:0];
  endfunction

  // round to nearest, ties toward +inf
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b) + 64'sd32768;
    return clamp(p >>> 16);
  endfunction

  // round to nearest, ties away from zero
  function automatic logic signed [31:0] qdiv(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    longint num, q;
    logic [63:0] un, ub;
    logic neg;
    num = longint'(a) * 64'sd65536;
    neg = (num < 0) != (b < 0);
    un = (num < 0) ? -num : num;
    ub = (b < 0) ? -longint'(b) : longint'(b);
    q = (un + ub / 2) / ub;
    return clamp(neg ? -q : q);
  endfunction

  task automatic sweep_row(input logic signed [31:0] lo_in, dg, up_in, rh,
                           input logic last);
    logic signed [31:0] lo, up, piv, c, d, x;
    soln_t s;
    lo = lo_in;
    up = last ? 32'sd0 : up_in;
    if (rows_held >= tts_pkg::MaxRows) begin
      run_status = tts_pkg::StatusOverflow;
    end else begin
      if (rows_held == 0) lo = 0;
      piv = clamp(longint'(dg) -
                  longint'(qmul(lo, rows_held ? c_mem[rows_held-1] : 32'sd0)));
      if (piv == 0) begin
        if (run_status != tts_pkg::StatusOverflow) run_status = tts_pkg::StatusZeroPiv;
        c = 0;
        d = 0;
      end else begin
        c = qdiv(up, piv);
        d = qdiv(clamp(longint'(rh) - longint'(qmul(lo,
                 rows_held ? d_mem[rows_held-1] : 32'sd0))), piv);
      end
      c_mem[rows_held] = c;
      d_mem[rows_held] = d;
      rows_held++;
    end
    if (last) begin
      x = 0;
      for (int i = rows_held - 1; i >= 0; i--) begin
        if (i == rows_held - 1) x = d_mem[i];
        else x = clamp(longint'(d_mem[i]) - longint'(qmul(c_mem[i], x)));
        s.solution = x;
        s.row_index = i[5:0];
        s.status = run_status;
        s.last_result = (i == 0);
        soln_q.push_back(s);
      end
      rows_held = 0;
      run_status = tts_pkg::StatusOk;
      solves_seen++;
    end
  endtask

  always @(posedge clk) begin
    soln_t e;
    int    errs;
    errs = 0;
    if (!rst_n) begin
      soln_q.delete();
      rows_held = 0;
      run_status = tts_pkg::StatusOk;
      fail_count <= 0;
      solves_seen = 0;
    end else begin
      if (in_valid && !in_stall)
        sweep_row(in_lower_coef, in_diag_coef, in_upper_coef, in_rhs_value,
                  in_last_row);
      if (out_valid && !out_stall) begin
        if (soln_q.size() == 0) begin
          $error("unexpected result word: solution %0d row %0d",
                 out_solution, out_row_index);
          errs++;
        end else begin
          e = soln_q.pop_front();
          if (out_solution !== e.solution) begin
            $error("solution: expected %0d, got %0d", e.solution, out_solution);
            errs++;
          end
          if (out_row_index !== e.row_index) begin
            $error("row_index: expected %0d, got %0d", e.row_index,
                   out_row_index);
            errs++;
          end
          if (out_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_status);
            errs++;
          end
          if (out_last_result !== e.last_result) begin
            $error("last_result: expected %0d, got %0d", e.last_result,
                   out_last_result);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending_count <= soln_q.size();
  end

endmodule

// ----- bench/tridiagonal_thomas_solver_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tridiagonal_thomas_solver_test: stimulus and verdict for the solver
// Feeds directed and random tridiagonal systems with random gaps on both
// channels; the checker predicts every solution word and counts failures.
// ----------------------------------------------------------------------------
module tridiagonal_thomas_solver_test;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_lower_coef;
  logic signed [31:0] in_diag_coef;
  logic signed [31:0] in_upper_coef;
  logic signed [31:0] in_rhs_value;
  logic               in_last_row;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_solution;
  logic [5:0]         out_row_index;
  logic [1:0]         out_status;
  logic               out_last_result;
  int                 fail_count;
  int                 pending_count;
  int                 solves_seen;
  int                 words_sent;
  int                 idle_cycles;

  // two divider passes per row plus long receiver stalls; generous margin
  localparam int IdleLimit = 20000;
  localparam int DrainWait = 300;

  tridiagonal_thomas_solver dut (.*);

  tts_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: count cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one, sometimes none at all.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Receiver: stall at random, independently of the sender.
  initial begin
    out_stall = 1'b0;
    forever begin
      repeat (gap_len()) @(posedge clk) out_stall <= 1'b1;
      @(posedge clk) out_stall <= 1'b0;
    end
  end

  // Mix of extremes, small values and full-range noise.
  function automatic logic signed [31:0] coef_value();
    case ($urandom_range(0, 7))
      0: return tts_pkg::SatMax;
      1: return tts_pkg::SatMin;
      2: return 32'sd0;
      3, 4: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $urandom();
    endcase
  endfunction

  // Hand over one row word and hold it until the block accepts it; drop
  // valid only for a gap, so back-to-back words keep it high.
  task automatic send_row(input logic signed [31:0] lo, dg, up, rh,
                          input logic last);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_lower_coef <= lo;
    in_diag_coef  <= dg;
    in_upper_coef <= up;
    in_rhs_value  <= rh;
    in_last_row   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Random system; the diagonal is mostly of moderate size so values stay meaningful.
  task automatic send_system(input int n);
    logic signed [31:0] dg;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0)
        dg = $signed($urandom_range(32'h20000, 32'h80000)) *
             ($urandom_range(0, 1) ? 1 : -1);
      else
        dg = coef_value();
      send_row(coef_value() >>> ($urandom_range(0, 1) ? 3 : 0), dg,
               coef_value() >>> ($urandom_range(0, 1) ? 3 : 0), coef_value(),
               i == n - 1);
    end
  endtask

  // Drop valid and hold off until every expected solution has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_count != 0 || (in_valid && !in_stall)) @(posedge clk);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_lower_coef = '0;
    in_diag_coef  = '0;
    in_upper_coef = '0;
    in_rhs_value  = '0;
    in_last_row   = 1'b0;
    words_sent    = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single-row system, extremes and saturation.
    send_row(tts_pkg::SatMin, 32'sh10000, tts_pkg::SatMax, tts_pkg::SatMax, 1'b1);
    send_row(tts_pkg::SatMax, tts_pkg::SatMin, tts_pkg::SatMin, tts_pkg::SatMin, 1'b1);
    send_row(32'sd0, 32'sd1, 32'sd0, tts_pkg::SatMax, 1'b1);
    // Zero pivot on a single row, then mid-system.
    send_row(32'sd5, 32'sd0, 32'sd7, 32'sh10000, 1'b1);
    send_row(32'sd0, 32'sh10000, 32'sh10000, 32'sh10000, 1'b0);
    send_row(32'sh10000, 32'sh10000, 32'sd3, 32'sh20000, 1'b0);
    send_row(32'sh10000, 32'sh30000, 32'sd0, 32'sh8000, 1'b1);
    // Rounding ties and negative values.
    send_row(32'sd0, -32'sd3, 32'sd1, -32'sd1, 1'b0);
    send_row(-32'sd1, 32'sd2, 32'sd0, 32'sd1, 1'b1);
    // Hold off until every expected solution has come out.
    wait_drained();

    // Too many rows on top of a zero pivot: fill capacity, then two extra
    // words, the last flagged.
    for (int i = 0; i < tts_pkg::MaxRows + 2; i++)
      send_row((i == 3) ? 32'sd0 : 32'sh8000, (i == 3) ? 32'sd0 : 32'sh40000,
               -32'sh8000, $urandom(), i == tts_pkg::MaxRows + 1);
    wait_drained();

    // Random: many short systems, now and then a longer one.
    while (words_sent < 120) begin
      send_system($urandom_range(0, 9) == 0 ? $urandom_range(8, 20)
                                            : $urandom_range(1, 5));
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (DrainWait) @(posedge clk);
    $display("covered %0d row words in %0d systems, incl. zero pivots, overflow",
             words_sent, solves_seen);
    $display("and saturating extremes, with random gaps on both channels");
    if (fail_count == 0 && pending_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
